// ===== hdl/sle_pkg.sv =====
// Shared widths, opcodes, status codes and controller/datapath interface types.
package sle_pkg;

    localparam int OP_W  = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;
    localparam int LEN_W = 9;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd3;
    localparam logic [OP_W-1:0] OP_DELMIN = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BADPOS  = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the request word
        logic decode;   // check request, set scan bounds
        logic step;     // issue one memory read, advance index
        logic finish;   // final write and length update
        logic emit;     // load the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic abort;     // request rejected, no memory work
        logic scan_need; // at least one entry to walk
        logic scan_last; // current index is the last of the walk
        logic out_free;  // output register can take a word
    } t_dp_stat;

endpackage

// ===== hdl/sle_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sle_ctrl.sv =====
// Request sequencer: decode, scan and finish as each request needs, then output.
module sle_ctrl
    import sle_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_FINISH = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.abort) begin
                    n_state = S_DONE;
                end else if (i_stat.scan_need) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read word lands here
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/sle_dp.sv =====
// List datapath: request registers, entry store, scan index, min/match tracking, output register.
module sle_dp
    import sle_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [OP_W-1:0]         i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_value_out,
    output logic [POS_W-1:0]        o_position_out,
    output logic [LEN_W-1:0]        o_list_length,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // request
    logic [OP_W-1:0]  r_op;
    logic [POS_W-1:0] r_pos;
    logic [VAL_W-1:0] r_val;

    // list state
    logic [CW-1:0] r_count;

    // scan
    logic [AW-1:0] r_idx, r_end;
    logic          r_up;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_addr;

    // per-request results
    logic [ST_W-1:0]  r_status;
    logic [VAL_W-1:0] r_vout;
    logic [POS_W-1:0] r_pout;
    logic [VAL_W-1:0] r_best;
    logic [AW-1:0]    r_at;
    logic [VAL_W-1:0] r_last;

    // output register
    logic             r_out_vld;
    logic [ST_W-1:0]  r_o_status;
    logic [VAL_W-1:0] r_o_vout;
    logic [POS_W-1:0] r_o_pout;
    logic [LEN_W-1:0] r_o_len;

    // decode
    logic [XW-1:0]   n_ext, p_ext, n_p1, p_sub, n_sub;
    logic [AW-1:0]   p_m1, n_m1;
    logic            pos_zero, cnt_full;
    logic [ST_W-1:0] d_status;
    logic            d_abort, d_scan, d_up;
    logic [AW-1:0]   d_start, d_end;

    // memory ports
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [VAL_W-1:0] mem_q;
    logic [AW:0]      rd_addr_p1;

    assign n_ext    = XW'(r_count);
    assign p_ext    = XW'(r_pos);
    assign n_p1     = n_ext + XW'(1);
    assign p_sub    = p_ext - XW'(1);
    assign n_sub    = n_ext - XW'(1);
    assign p_m1     = p_sub[AW-1:0];
    assign n_m1     = n_sub[AW-1:0];
    assign pos_zero = (r_pos == '0);
    assign cnt_full = (r_count == CW'(DEPTH));

    always_comb begin
        d_status = ST_OK;
        d_abort  = 1'b0;
        d_scan   = 1'b0;
        d_up     = 1'b1;
        d_start  = '0;
        d_end    = '0;
        unique case (r_op)
            OP_INSERT: begin
                if (pos_zero || (p_ext > n_p1)) begin
                    d_status = ST_BADPOS;
                    d_abort  = 1'b1;
                end else if (cnt_full) begin
                    d_status = ST_FULL;
                    d_abort  = 1'b1;
                end else begin
                    // move entries p-1..n-1 up one, top first
                    d_scan  = (p_ext <= n_ext);
                    d_up    = 1'b0;
                    d_start = n_m1;
                    d_end   = p_m1;
                end
            end
            OP_DELETE, OP_GET: begin
                if (pos_zero || (p_ext > n_ext)) begin
                    d_status = ST_BADPOS;
                    d_abort  = 1'b1;
                end else begin
                    d_scan  = 1'b1;
                    d_start = p_m1;
                    d_end   = (r_op == OP_GET) ? p_m1 : n_m1;
                end
            end
            OP_LOCATE: begin
                d_status = ST_MISSING;
                d_scan   = (r_count != '0);
                d_end    = n_m1;
            end
            OP_DELMIN: begin
                if (r_count == '0) begin
                    d_status = ST_EMPTY;
                    d_abort  = 1'b1;
                end else begin
                    d_scan = 1'b1;
                    d_end  = n_m1;
                end
            end
            default: begin
                d_status = ST_BADPOS;
                d_abort  = 1'b1;
            end
        endcase
    end

    assign rd_addr_p1 = {1'b0, r_rd_addr} + (AW+1)'(1);

    // write port: shifts during the walk, final store on finish
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = mem_q;
        if (r_rd_vld) begin
            if (r_op == OP_INSERT) begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr_p1[AW-1:0];
            end else if ((r_op == OP_DELETE) && (r_rd_addr != p_m1)) begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_addr - AW'(1);
            end
        end else if (i_cmd.finish) begin
            if (r_op == OP_INSERT) begin
                mem_we    = 1'b1;
                mem_waddr = p_m1;
                mem_wdata = r_val;
            end else if (r_op == OP_DELMIN) begin
                // last entry fills the vacated slot
                mem_we    = 1'b1;
                mem_waddr = r_at;
                mem_wdata = r_last;
            end
        end
    end

    sle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req_type;
            r_pos <= i_position;
            r_val <= i_value;
        end

        if (i_cmd.decode) begin
            r_status <= d_status;
            r_vout   <= '0;
            r_pout   <= '0;
            r_idx    <= d_start;
            r_end    <= d_end;
            r_up     <= d_up;
        end

        if (i_cmd.step && (r_idx != r_end)) begin
            r_idx <= r_up ? (r_idx + AW'(1)) : (r_idx - AW'(1));
        end
        r_rd_addr <= r_idx;

        // returning read word
        if (r_rd_vld) begin
            unique case (r_op)
                OP_DELETE: begin
                    if (r_rd_addr == p_m1) begin
                        r_vout <= mem_q;
                    end
                end
                OP_GET: begin
                    r_vout <= mem_q;
                end
                OP_LOCATE: begin
                    if ((mem_q == r_val) && (r_status == ST_MISSING)) begin
                        r_status <= ST_OK;
                        r_pout   <= POS_W'(rd_addr_p1);
                    end
                end
                OP_DELMIN: begin
                    r_last <= mem_q;
                    if ((r_rd_addr == '0) || ($signed(mem_q) < $signed(r_best))) begin
                        r_best <= mem_q;
                        r_at   <= r_rd_addr;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.finish && (r_op == OP_DELMIN)) begin
            r_vout <= r_best;
        end

        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_vout   <= r_vout;
            r_o_pout   <= r_pout;
            r_o_len    <= LEN_W'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cmd.finish) begin
                if (r_op == OP_INSERT) begin
                    r_count <= r_count + CW'(1);
                end else if ((r_op == OP_DELETE) || (r_op == OP_DELMIN)) begin
                    r_count <= r_count - CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.abort     = d_abort;
    assign o_stat.scan_need = d_scan;
    assign o_stat.scan_last = (r_idx == r_end);
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_o_status;
    assign o_value_out    = r_o_vout;
    assign o_position_out = r_o_pout;
    assign o_list_length  = r_o_len;

endmodule

// ===== hdl/sequential_list_engine_top.sv =====
// Top level of the packed list engine: sequencer plus datapath.
//
//  channel | valid / ready             | word
//  --------+---------------------------+--------------------------------------------
//  request | i_in_valid / o_in_ready   | i_req_type, i_position, i_value
//  result  | o_out_valid / i_out_ready | o_status, o_value_out, o_position_out,
//          |                           | o_list_length
//
// One request at a time. Each request walks k entries through the single-read-port
// store: n-p+1 for insert, n-p+1 for delete, 1 for get, n for locate and delete-min;
// nothing is walked for rejected requests. The next request is taken once the
// result loads into the output register.
// Reset clears the length and both valid flags; store contents need no clear.
// A result waiting in the output register does not block the next request;
// only the final hand-off into that register waits on i_out_ready.
module sequential_list_engine_top
    import sle_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_value_out,
    output logic [POS_W-1:0]        o_position_out,
    output logic [LEN_W-1:0]        o_list_length
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    sle_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_value_out    (o_value_out),
        .o_position_out (o_position_out),
        .o_list_length  (o_list_length),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat)
    );

endmodule

// ===== tb/sequential_list_engine_top_test.sv =====
// Self-checking testbench for the packed list engine: queued stimulus, list predictor, result checker.
`timescale 1ns / 1ps

module sequential_list_engine_top_test;
    import sle_pkg::*;

    localparam int DEPTH           = 256;
    localparam int ITEMS_PER_PHASE = 400;
    localparam int CYCLE_LIMIT     = 2_000_000;

    localparam logic [OP_W-1:0]         OP_UNUSED_LO = OP_DELMIN + OP_W'(1);
    localparam logic [OP_W-1:0]         OP_UNUSED_HI = '1;
    localparam logic signed [VAL_W-1:0] VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } t_list_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] value_out;
        logic [POS_W-1:0]        position_out;
        logic [LEN_W-1:0]        list_length;
    } t_list_rsp;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_req_type = '0;
    logic [POS_W-1:0]        i_position = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_value_out;
    logic [POS_W-1:0]        o_position_out;
    logic [LEN_W-1:0]        o_list_length;

    sequential_list_engine_top #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_value_out    (o_value_out),
        .o_position_out (o_position_out),
        .o_list_length  (o_list_length)
    );

    always #1 i_clk = ~i_clk;

    t_list_req               req_q[$];
    t_list_rsp               expected_q[$];
    logic signed [VAL_W-1:0] shadow_list [DEPTH];
    int                      shadow_len = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      error_count = 0;
    int                      cycle_count = 0;
    int                      target_len = 0;
    int                      dwell_left = 0;
    bit                      in_accept;
    t_list_rsp               want;

    // Applies one request word to the shadow list and returns the result it should produce.
    function automatic t_list_rsp apply_request(t_list_req rq);
        t_list_rsp               rs;
        int                      p;
        int                      idx;
        int                      best_at;
        logic signed [VAL_W-1:0] best;
        rs = '0;
        rs.status = ST_OK;
        p = int'(rq.pos);
        case (rq.op)
            OP_INSERT: begin
                if (p < 1 || p > shadow_len + 1) begin
                    rs.status = ST_BADPOS;
                end else if (shadow_len >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    for (idx = shadow_len; idx >= p; idx--)
                        shadow_list[idx] = shadow_list[idx-1];
                    shadow_list[p-1] = rq.val;
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > shadow_len) begin
                    rs.status = ST_BADPOS;
                end else begin
                    rs.value_out = shadow_list[p-1];
                    for (idx = p; idx < shadow_len; idx++)
                        shadow_list[idx-1] = shadow_list[idx];
                    shadow_len--;
                end
            end
            OP_GET: begin
                if (p < 1 || p > shadow_len)
                    rs.status = ST_BADPOS;
                else
                    rs.value_out = shadow_list[p-1];
            end
            OP_LOCATE: begin
                rs.status = ST_MISSING;
                for (idx = 0; idx < shadow_len; idx++) begin
                    if (shadow_list[idx] == rq.val) begin
                        rs.status = ST_OK;
                        rs.position_out = POS_W'(idx + 1);
                        break;
                    end
                end
            end
            OP_DELMIN: begin
                if (shadow_len == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    best = shadow_list[0];
                    best_at = 0;
                    // strict less-than keeps the first of equal minimums
                    for (idx = 1; idx < shadow_len; idx++) begin
                        if (shadow_list[idx] < best) begin
                            best = shadow_list[idx];
                            best_at = idx;
                        end
                    end
                    shadow_list[best_at] = shadow_list[shadow_len-1];
                    shadow_len--;
                    rs.value_out = best;
                end
            end
            default: rs.status = ST_BADPOS;
        endcase
        rs.list_length = LEN_W'(shadow_len);
        return rs;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        // small pool makes duplicates, ties and locate hits common
        if (r < 35)
            return VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
        if (r < 45) begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return VAL_W'($urandom);
    endfunction

    // Builds the next request from the current shadow length, steering toward target_len.
    function automatic t_list_req gen_request();
        t_list_req rq;
        int        r;
        int        n;
        bit        grow;
        bit        shrink;
        n = shadow_len;
        if (dwell_left > 0) begin
            dwell_left--;
            if (dwell_left == 0)
                target_len = ($urandom_range(0, 39) == 0) ? $urandom_range(DEPTH / 2, DEPTH)
                                                          : $urandom_range(0, 16);
        end else if (n == target_len) begin
            dwell_left = $urandom_range(4, 12);
        end
        grow   = (dwell_left == 0) && (n < target_len);
        shrink = (dwell_left == 0) && (n > target_len);

        r = $urandom_range(0, 99);
        if (r < 4) begin
            rq.op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            r = $urandom_range(0, 99);
            if (grow)
                rq.op = (r < 80) ? OP_INSERT : (r < 84) ? OP_DELETE : (r < 90) ? OP_GET :
                        (r < 96) ? OP_LOCATE : OP_DELMIN;
            else if (shrink)
                rq.op = (r < 5) ? OP_INSERT : (r < 45) ? OP_DELETE : (r < 52) ? OP_GET :
                        (r < 60) ? OP_LOCATE : OP_DELMIN;
            else
                rq.op = (r < 22) ? OP_INSERT : (r < 40) ? OP_DELETE : (r < 60) ? OP_GET :
                        (r < 80) ? OP_LOCATE : OP_DELMIN;
        end

        r = $urandom_range(0, 99);
        if (r < 8) begin
            // out of range: just past the end, or any 9-bit pattern
            if ($urandom_range(0, 1))
                rq.pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
            else
                rq.pos = POS_W'(n + 1 + ((rq.op == OP_INSERT) ? 1 : 0));
        end else if (rq.op == OP_INSERT) begin
            case ($urandom_range(0, 2))
                0:       rq.pos = POS_W'(1);
                1:       rq.pos = POS_W'(n + 1);
                default: rq.pos = POS_W'($urandom_range(1, n + 1));
            endcase
        end else if (n == 0) begin
            rq.pos = POS_W'($urandom_range(0, 2));
        end else begin
            case ($urandom_range(0, 2))
                0:       rq.pos = POS_W'(1);
                1:       rq.pos = POS_W'(n);
                default: rq.pos = POS_W'($urandom_range(1, n));
            endcase
        end

        rq.val = pick_value();
        if (rq.op == OP_LOCATE && n > 0 && $urandom_range(0, 99) < 65)
            rq.val = shadow_list[$urandom_range(0, n - 1)];
        return rq;
    endfunction

    // Queue one word and hold off until the driver has handed it over.
    task automatic issue(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val);
        t_list_req rq;
        rq.op  = op;
        rq.pos = pos;
        rq.val = val;
        req_q.push_back(rq);
        do @(negedge i_clk); while (req_q.size() != 0);
    endtask

    task automatic drain();
        do @(negedge i_clk); while (req_q.size() != 0 || expected_q.size() != 0);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            in_accept = i_in_valid && o_in_ready;
            if (in_accept)
                expected_q.push_back(apply_request(req_q.pop_front()));
            if (!i_in_valid || in_accept) begin
                if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_req_type <= req_q[0].op;
                    i_position <= req_q[0].pos;
                    i_value    <= req_q[0].val;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_value_out !== want.value_out) begin
                        $error("value_out mismatch: expected %0d, got %0d",
                               want.value_out, o_value_out);
                        error_count++;
                    end
                    if (o_position_out !== want.position_out) begin
                        $error("position_out mismatch: expected %0d, got %0d",
                               want.position_out, o_position_out);
                        error_count++;
                    end
                    if (o_list_length !== want.list_length) begin
                        $error("list_length mismatch: expected %0d, got %0d",
                               want.list_length, o_list_length);
                        error_count++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_list_req rq;
        int        phase;
        int        k;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 14;
        recv_idle_pct = 55;

        // directed: empty list, bounds, extremes, ties, unused opcodes
        issue(OP_DELMIN, 0, 0);
        issue(OP_LOCATE, 1, 0);
        issue(OP_GET,    1, 0);
        issue(OP_DELETE, 0, 0);
        issue(OP_INSERT, 0, 5);
        issue(OP_INSERT, 2, 5);
        issue(OP_INSERT, 1, VAL_MAX);
        issue(OP_INSERT, 1, VAL_MIN);
        issue(OP_INSERT, 3, -1);
        issue(OP_INSERT, 2, -1);
        issue(OP_INSERT, 5, VAL_MIN);
        issue(OP_GET,    5, 0);
        issue(OP_GET,    6, 0);
        issue(OP_LOCATE, 0, -1);
        issue(OP_LOCATE, 3, 12345);
        issue(OP_DELMIN, 0, 0);
        issue(OP_DELETE, 4, 0);
        issue(OP_DELETE, 1, 0);
        issue(OP_UNUSED_LO, 1, 0);
        issue(OP_UNUSED_LO + OP_W'(1), 2, VAL_MAX);
        issue(OP_UNUSED_HI, '1, '1);
        issue(OP_INSERT, '1, 7);
        issue(OP_LOCATE, 0, VAL_MAX);
        issue(OP_DELMIN, 0, 0);
        issue(OP_DELETE, 1, 0);
        drain();

        // first episode fills the list to capacity, later targets are mostly short
        target_len = DEPTH;
        dwell_left = 0;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 14;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                rq = gen_request();
                issue(rq.op, rq.pos, rq.val);
            end
            drain();
        end

        repeat (DEPTH + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
